/* hw/rtl/hoc_pkg.sv */
package hoc_pkg;

  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned BINS       = 256;
  localparam int unsigned LVL_W      = 3;
  localparam int unsigned NUM_SPLITS = 8;
  localparam int unsigned K_W        = 3;
  localparam int unsigned PROD_W     = CNT_W + K_W;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [K_W-1:0]   K_FIRST = 3'd1;
  localparam logic [K_W-1:0]   K_LAST  = 3'd7;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // split register write from the scan sequencer
  typedef struct packed {
    logic             we;
    logic [K_W-1:0]   idx;
    logic [PIX_W-1:0] val;
  } hoc_split_wr_t;

  // scan sequencer status toward the top level
  typedef struct packed {
    logic [PIX_W-1:0] rd_addr;
    logic             done;
  } hoc_scan_t;

endpackage

/* hw/rtl/hoc_hist_ram.sv */
module hoc_hist_ram (
  input  logic                           clk,
  input  logic                           we,
  input  logic [hoc_pkg::PIX_W-1:0]      waddr,
  input  logic [hoc_pkg::CNT_W-1:0]      wdata,
  input  logic [hoc_pkg::PIX_W-1:0]      raddr,
  output logic [hoc_pkg::CNT_W-1:0]      rdata
);

  logic [hoc_pkg::CNT_W-1:0] mem [hoc_pkg::BINS];
  logic [hoc_pkg::CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/hoc_split_scan.sv */
module hoc_split_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hoc_pkg::CNT_W-1:0]  count,
  input  logic [hoc_pkg::CNT_W-1:0]  rdata,
  output hoc_pkg::hoc_scan_t         status,
  output hoc_pkg::hoc_split_wr_t     split_wr
);

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_LOAD  = 2'd1;
  localparam logic [1:0] P_FIRST = 2'd2;
  localparam logic [1:0] P_RUN   = 2'd3;

  logic [1:0]                  phase_r, phase_nxt;
  logic [hoc_pkg::PIX_W-1:0]   s_r, s_nxt;
  logic [hoc_pkg::CNT_W-1:0]   cum_r, cum_nxt;
  logic [hoc_pkg::K_W-1:0]     k_r, k_nxt;
  logic                        fresh_r, fresh_nxt;

  logic [hoc_pkg::PROD_W-1:0]  prod;
  logic [hoc_pkg::CNT_W-1:0]   thr;
  logic [hoc_pkg::CNT_W:0]     cand;
  logic                        fits;
  logic                        adv;
  logic                        emit;

  // threshold floor(count*k/8)
  assign prod = hoc_pkg::PROD_W'(count) * hoc_pkg::PROD_W'(k_r);
  assign thr  = prod[hoc_pkg::PROD_W-1:hoc_pkg::K_W];
  assign cand = {1'b0, cum_r} + {1'b0, rdata};
  assign fits = (cand <= {1'b0, thr});

  always_comb begin
    phase_nxt = phase_r;
    s_nxt     = s_r;
    cum_nxt   = cum_r;
    k_nxt     = k_r;
    fresh_nxt = fresh_r;
    adv       = 1'b0;
    emit      = 1'b0;
    unique case (phase_r)
      P_IDLE: begin
        if (start) begin
          phase_nxt = P_LOAD;
        end
      end
      P_LOAD: begin
        // split starts at bin 0 so the next step fetches bin 1
        s_nxt     = '0;
        phase_nxt = P_FIRST;
      end
      P_FIRST: begin
        cum_nxt   = rdata;
        s_nxt     = '0;
        k_nxt     = hoc_pkg::K_FIRST;
        fresh_nxt = 1'b1;
        phase_nxt = P_RUN;
      end
      P_RUN: begin
        if (s_r == hoc_pkg::PIX_MAX) begin
          emit = 1'b1;
        end else if (fresh_r) begin
          if (fits) begin
            adv = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        if (adv) begin
          s_nxt     = s_r + 1'b1;
          cum_nxt   = cand[hoc_pkg::CNT_W-1:0];
          fresh_nxt = 1'b0;
        end else begin
          fresh_nxt = 1'b1;
        end
        if (emit) begin
          if (k_r == hoc_pkg::K_LAST) begin
            phase_nxt = P_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      fresh_r <= 1'b0;
      k_r     <= hoc_pkg::K_FIRST;
    end else begin
      phase_r <= phase_nxt;
      fresh_r <= fresh_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    cum_r <= cum_nxt;
  end

  // bin s+1 is fetched while s is held; bin 0 on the load step
  assign status.rd_addr = (phase_r == P_LOAD) ? '0 : s_r + 1'b1;
  assign status.done    = (phase_r == P_RUN) && emit && (k_r == hoc_pkg::K_LAST);

  assign split_wr.we  = (phase_r == P_RUN) && emit;
  assign split_wr.idx = k_r - 1'b1;
  assign split_wr.val = s_r;

endmodule

/* hw/rtl/hoc_classify.sv */
module hoc_classify (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hoc_pkg::hoc_split_wr_t      split_wr,
  input  logic                        req,
  input  logic [hoc_pkg::PIX_W-1:0]   pixel,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [hoc_pkg::LVL_W-1:0]   out_level
);

  localparam int unsigned NSTORED = hoc_pkg::NUM_SPLITS - 1;

  // the eighth split is fixed at the top gray value
  logic [hoc_pkg::PIX_W-1:0] split_r [NSTORED];
  logic                      valid_r, valid_nxt;
  logic [hoc_pkg::LVL_W-1:0] level_r;
  logic [hoc_pkg::LVL_W-1:0] level_c;

  always_comb begin
    level_c = hoc_pkg::LVL_W'(NSTORED);
    for (int i = NSTORED - 1; i >= 0; i--) begin
      if (pixel <= split_r[i]) begin
        level_c = hoc_pkg::LVL_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTORED; i++) begin
        split_r[i] <= '0;
      end
    end else if (split_wr.we) begin
      split_r[split_wr.idx] <= split_wr.val;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (req) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      level_r <= level_c;
    end
  end

  assign out_valid = valid_r;
  assign out_level = level_r;

endmodule

/* hw/rtl/histogram_octile_pixel_classifier_unit.sv */
// add requests: one per cycle when ready, no result; bin written the next cycle
// classify: one per cycle when ready, level registered and shown the next cycle
// last pixel: a drain step, the split scan, then the 256 bins are cleared
// reset: synchronous, clears the 256 bins before requests are taken;
//   splits reset to zero with the eighth fixed at 255
module histogram_octile_pixel_classifier_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [hoc_pkg::PIX_W-1:0]   in_pixel,
  input  logic                        in_last_pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hoc_pkg::LVL_W-1:0]   out_level
);

  // control states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_CLEAR = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [hoc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [hoc_pkg::PIX_W-1:0]   clr_addr_r, clr_addr_nxt;

  // bin update stage: read issued on accept, write in the next cycle
  logic                        acc_v_r;
  logic [hoc_pkg::PIX_W-1:0]   acc_addr_r;
  // last write, forwarded when the next update hits the same bin
  logic                        fw_v_r;
  logic [hoc_pkg::PIX_W-1:0]   fw_addr_r;
  logic [hoc_pkg::CNT_W-1:0]   fw_data_r;

  logic                        accept;
  logic                        add_req;
  logic                        cls_req;
  logic                        add_take;
  logic [hoc_pkg::CNT_W-1:0]   old_bin;
  logic [hoc_pkg::CNT_W-1:0]   new_bin;

  logic                        ram_we;
  logic [hoc_pkg::PIX_W-1:0]   ram_waddr;
  logic [hoc_pkg::CNT_W-1:0]   ram_wdata;
  logic [hoc_pkg::PIX_W-1:0]   ram_raddr;
  logic [hoc_pkg::CNT_W-1:0]   ram_rdata;

  hoc_pkg::hoc_scan_t          scan_st;
  hoc_pkg::hoc_split_wr_t      split_wr;
  logic                        res_valid;

  // output register parts the two sides: a new request enters while the
  // held level is being taken
  assign in_ready = (state_r == S_IDLE) && (!res_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign add_req  = accept && (in_operation == hoc_pkg::OP_ADD);
  assign cls_req  = accept && (in_operation == hoc_pkg::OP_CLASSIFY);
  // a saturated count drops the pixel but keeps its last mark
  assign add_take = add_req && (count_r != hoc_pkg::CNT_MAX);

  // read-modify-write of one bin with forwarding of the previous write
  assign old_bin = (fw_v_r && (fw_addr_r == acc_addr_r)) ? fw_data_r : ram_rdata;
  assign new_bin = old_bin + 1'b1;

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = acc_addr_r;
    ram_wdata = new_bin;
    ram_raddr = in_pixel;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (acc_v_r) begin
      ram_we = 1'b1;
    end
    if (state_r == S_SCAN) begin
      ram_raddr = scan_st.rd_addr;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (add_take) begin
          count_nxt = count_r + 1'b1;
        end
        if (add_req && in_last_pixel) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last bin write lands before the scan reads
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_st.done) begin
          state_nxt    = S_CLEAR;
          clr_addr_nxt = '0;
        end
      end
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == hoc_pkg::PIX_MAX) begin
          state_nxt = S_IDLE;
          count_nxt = '0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      count_r    <= '0;
      clr_addr_r <= '0;
      acc_v_r    <= 1'b0;
      fw_v_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      clr_addr_r <= clr_addr_nxt;
      acc_v_r    <= add_take;
      fw_v_r     <= acc_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (add_take) begin
      acc_addr_r <= in_pixel;
    end
    if (acc_v_r) begin
      fw_addr_r <= acc_addr_r;
      fw_data_r <= new_bin;
    end
  end

  hoc_hist_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hoc_split_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DRAIN),
    .count    (count_r),
    .rdata    (ram_rdata),
    .status   (scan_st),
    .split_wr (split_wr)
  );

  hoc_classify u_cls (
    .clk       (clk),
    .rst_n     (rst_n),
    .split_wr  (split_wr),
    .req       (cls_req),
    .pixel     (in_pixel),
    .out_ready (out_ready),
    .out_valid (res_valid),
    .out_level (out_level)
  );

  assign out_valid = res_valid;

endmodule

/* sim/tb_histogram_octile_pixel_classifier_unit.sv */
module tb_histogram_octile_pixel_classifier_unit;
  import hoc_pkg::*;

  // slowest correct run: about 2000 requests with long output stalls, and around a hundred
  // split scans, each followed by a bin clear; all well within the cycle limit
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  // longest internal work after the last request: split scan plus bin clear
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned QUEUE_DEPTH  = 256;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pix;
    logic             last;
  } pixel_req_t;

  // pixel distributions used to build random images
  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_CLUSTER,
    SPREAD_EXTREMES,
    SPREAD_FEW
  } spread_e;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic             in_operation  = OP_ADD;
  logic [PIX_W-1:0] in_pixel      = '0;
  logic             in_last_pixel = 1'b0;
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic [LVL_W-1:0] out_level;

  // requests waiting to be offered, and levels waiting to come out
  pixel_req_t       request_q[$];
  logic [LVL_W-1:0] level_q[$];

  // mirror of the block state: bins, pixels of the open image, split points
  int unsigned      bin_count[BINS];
  int unsigned      image_pixels = 0;
  logic [PIX_W-1:0] split_at[NUM_SPLITS];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  bit          in_taken      = 1'b0;

  histogram_octile_pixel_classifier_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_pixel      (in_pixel),
    .in_last_pixel (in_last_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_level     (out_level)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // add one pixel to the open image; on the last mark find the octile splits
  // and start a fresh image
  function automatic void track_pixel(logic [PIX_W-1:0] pix, logic last);
    int unsigned      cum[BINS];
    int unsigned      run;
    int unsigned      s;
    longint unsigned  thr;
    if (image_pixels < MAX_PIXELS) begin
      bin_count[pix]++;
      image_pixels++;
    end
    if (last) begin
      run = 0;
      for (int b = 0; b < BINS; b++) begin
        run += bin_count[b];
        cum[b] = run;
      end
      // each split picks up where the one before stopped
      s = 0;
      for (int k = 1; k < NUM_SPLITS; k++) begin
        thr = (longint'(image_pixels) * k) / 8;
        while (s < PIX_MAX && cum[s + 1] <= thr) s++;
        split_at[k - 1] = PIX_W'(s);
      end
      split_at[NUM_SPLITS - 1] = PIX_MAX;
      for (int b = 0; b < BINS; b++) bin_count[b] = 0;
      image_pixels = 0;
    end
  endfunction

  // smallest level whose split is at or above the pixel
  function automatic logic [LVL_W-1:0] octile_level(logic [PIX_W-1:0] pix);
    int unsigned h;
    h = 0;
    while (h < NUM_SPLITS - 1 && pix > split_at[h]) h++;
    return LVL_W'(h);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(spread_e spread, logic [PIX_W-1:0] base);
    case (spread)
      SPREAD_FULL:     return PIX_W'($urandom);
      SPREAD_CLUSTER:  return base + PIX_W'($urandom_range(3));
      SPREAD_EXTREMES: return $urandom_range(1) ? PIX_MAX : '0;
      default:         return base + PIX_W'(64 * $urandom_range(3));
    endcase
  endfunction

  // keep the pending list short so that a huge image does not sit in memory
  task automatic queue_req(logic op, logic [PIX_W-1:0] pix, logic last);
    pixel_req_t r;
    r.op   = op;
    r.pix  = pix;
    r.last = last;
    while (request_q.size() >= QUEUE_DEPTH) @(posedge clk);
    request_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || level_q.size() != 0) @(posedge clk);
  endtask

  // random images with random content; a few stay open, a few classify
  // requests land inside an image, and some classify requests carry a stray last mark
  task automatic gen_traffic(input int unsigned budget);
    int unsigned      made;
    int unsigned      npix;
    int unsigned      nclass;
    bit               open_img;
    spread_e          spread;
    logic [PIX_W-1:0] base;
    made = 0;
    while (made < budget) begin
      npix     = ($urandom_range(15) == 0) ? $urandom_range(300, 100) : $urandom_range(24, 1);
      spread   = spread_e'($urandom_range(3));
      base     = PIX_W'($urandom);
      open_img = ($urandom_range(9) == 0);
      for (int i = 0; i < npix; i++) begin
        queue_req(OP_ADD, pick_pixel(spread, base), !open_img && i == npix - 1);
        if ($urandom_range(24) == 0)
          queue_req(OP_CLASSIFY, PIX_W'($urandom), 1'($urandom_range(1)));
      end
      // probe around the image's own values so the splits are hit on both sides
      nclass = $urandom_range(16, 3);
      for (int i = 0; i < nclass; i++)
        queue_req(OP_CLASSIFY, pick_pixel(spread, base) + PIX_W'($urandom_range(2)) - 1'b1,
                  $urandom_range(3) == 0);
      made += npix + nclass;
    end
  endtask

  // request side: sample the handshake at the rising edge and update the mirror
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      if (in_operation == OP_CLASSIFY) level_q.push_back(octile_level(in_pixel));
      else track_pixel(in_pixel, in_last_pixel);
    end
  end

  // request driver: a new request only once the previous one went through
  always @(negedge clk) begin
    pixel_req_t r;
    if (rst_n && (!in_valid || in_taken)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r             = request_q.pop_front();
        in_valid      <= 1'b1;
        in_operation  <= r.op;
        in_pixel      <= r.pix;
        in_last_pixel <= r.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready: a long hold when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check against the oldest expected level, then the cycle limit
  always @(posedge clk) begin
    logic [LVL_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        $error("level: expected none, actual %0d", out_level);
        fail_cnt++;
      end else begin
        want = level_q.pop_front();
        if (out_level !== want) begin
          $error("level: expected %0d, actual %0d", want, out_level);
          fail_cnt++;
        end
      end
    end
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_SPLITS; i++) split_at[i] = '0;
    split_at[NUM_SPLITS - 1] = PIX_MAX;
    send_idle_pct = 23;
    recv_idle_pct = 80;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset splits: only pixel 0 maps to the darkest level; last mark on a
    // classify request is ignored
    queue_req(OP_CLASSIFY, '0, 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(1), 1'b0);
    queue_req(OP_CLASSIFY, PIX_MAX, 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(128), 1'b1);
    // one dark pixel image: all splits stay at zero
    queue_req(OP_ADD, '0, 1'b1);
    queue_req(OP_CLASSIFY, '0, 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(1), 1'b0);
    // one bright pixel image: splits run up to 254
    queue_req(OP_ADD, PIX_MAX, 1'b1);
    queue_req(OP_CLASSIFY, PIX_W'(254), 1'b0);
    queue_req(OP_CLASSIFY, PIX_MAX, 1'b0);
    // eight evenly spaced pixels: one per octile
    for (int i = 0; i < 8; i++) queue_req(OP_ADD, PIX_W'(i * 32), i == 7);
    queue_req(OP_CLASSIFY, '0, 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(31), 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(32), 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(224), 1'b0);
    queue_req(OP_CLASSIFY, PIX_W'(225), 1'b0);
    wait_drained();

    // long output hold while classify requests keep coming: the block backs up
    hold_left = 300;
    for (int i = 0; i < 60; i++) queue_req(OP_CLASSIFY, PIX_W'($urandom), 1'($urandom_range(1)));
    // sender pauses here until every level is back
    wait_drained();

    gen_traffic(650);

    send_idle_pct = 80;
    recv_idle_pct = 23;
    gen_traffic(650);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // two-pixel image at both ends of the range, then a sweep of classify requests
    queue_req(OP_ADD, '0, 1'b0);
    queue_req(OP_ADD, PIX_MAX, 1'b1);
    for (int i = 0; i < 16; i++) queue_req(OP_CLASSIFY, PIX_W'(i * 17), 1'b0);
    gen_traffic(700);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && level_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
